>>> src/kmc_pkg.sv
// Package: constants, types, keyword table and helper functions for the keyword counter
`timescale 1ns / 1ps
`default_nettype none
package kmc_pkg;

  localparam int NUM_KEYWORDS  = 32;
  localparam int MAX_KEY_CHARS = 8;
  localparam int COUNT_WIDTH   = 32;

  localparam int ROM_SIZE   = 32;
  localparam int ROM_IDX_W  = 5;
  localparam int WORD_W     = 64;
  localparam int OUT_IDX_W  = 5;
  localparam int OUT_CNT_W  = 32;

  localparam int KW_USED  = (NUM_KEYWORDS < ROM_SIZE) ? NUM_KEYWORDS : ROM_SIZE;
  localparam int KW_IDX_W = (KW_USED > 1) ? $clog2(KW_USED) : 1;
  localparam int KW_CNT_W = $clog2(KW_USED + 1);

  // item commands
  localparam logic CMD_COUNT  = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  localparam logic [WORD_W-1:0] TAIL_MASK = (MAX_KEY_CHARS >= 8) ? '0 :
      ((64'd1 << (WORD_W - 8 * MAX_KEY_CHARS)) - 64'd1);

  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [KW_IDX_W-1:0]    kw_idx_t;
  typedef logic [KW_CNT_W-1:0]    kw_cnt_t;
  typedef logic [KW_USED-1:0]     kw_mask_t;

  typedef struct packed {
    logic  start;
    word_t word;
  } srch_req_t;

  typedef struct packed {
    logic    done;
    logic    hit;
    kw_idx_t probe;
  } srch_rsp_t;

  // sorted keyword table, first character in the top byte, zero padded
  function automatic word_t keyword_rom(input logic [ROM_IDX_W-1:0] i);
    word_t k;
    unique case (i)
      5'd0:  k = {"auto", 32'h0};
      5'd1:  k = {"break", 24'h0};
      5'd2:  k = {"case", 32'h0};
      5'd3:  k = {"char", 32'h0};
      5'd4:  k = {"const", 24'h0};
      5'd5:  k = "continue";
      5'd6:  k = {"default", 8'h0};
      5'd7:  k = {"do", 48'h0};
      5'd8:  k = {"double", 16'h0};
      5'd9:  k = {"else", 32'h0};
      5'd10: k = {"enum", 32'h0};
      5'd11: k = {"extern", 16'h0};
      5'd12: k = {"float", 24'h0};
      5'd13: k = {"for", 40'h0};
      5'd14: k = {"goto", 32'h0};
      5'd15: k = {"if", 48'h0};
      5'd16: k = {"int", 40'h0};
      5'd17: k = {"long", 32'h0};
      5'd18: k = "register";
      5'd19: k = {"return", 16'h0};
      5'd20: k = {"short", 24'h0};
      5'd21: k = {"signed", 16'h0};
      5'd22: k = {"sizeof", 16'h0};
      5'd23: k = {"static", 16'h0};
      5'd24: k = {"struct", 16'h0};
      5'd25: k = {"switch", 16'h0};
      5'd26: k = {"typedef", 8'h0};
      5'd27: k = {"union", 24'h0};
      5'd28: k = "unsigned";
      5'd29: k = {"void", 32'h0};
      5'd30: k = "volatile";
      5'd31: k = {"while", 24'h0};
    endcase
    return k;
  endfunction

  // letter first, not over-long, nothing beyond the longest keyword
  function automatic logic word_eligible(input word_t w, input logic too_long);
    logic [7:0] first;
    logic       alpha;
    first = w[WORD_W-1 -: 8];
    alpha = (first >= 8'h41 && first <= 8'h5A) || (first >= 8'h61 && first <= 8'h7A);
    return alpha && !too_long && ((w & TAIL_MASK) == '0);
  endfunction

  function automatic logic [OUT_CNT_W-1:0] count_out(input count_t c);
    logic [63:0] wide;
    wide = 64'(c);
    return wide[OUT_CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/kmc_if.sv
// Interfaces: word input channel and result output channel
`timescale 1ns / 1ps
`default_nettype none
interface kmc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [kmc_pkg::WORD_W-1:0] word_text;
  logic                       word_too_long;

  modport source (output valid, cmd, word_text, word_too_long, input ready);
  modport sink   (input valid, cmd, word_text, word_too_long, output ready);
endinterface

interface kmc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [kmc_pkg::OUT_IDX_W-1:0] keyword_index;
  logic [kmc_pkg::OUT_CNT_W-1:0] keyword_count;
  logic                          last;

  modport source (output valid, found, keyword_index, keyword_count, last, input ready);
  modport sink   (input valid, found, keyword_index, keyword_count, last, output ready);
endinterface
`default_nettype wire

>>> src/kmc_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module kmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> src/kmc_search.sv
// Binary search unit: one table probe and one 64-bit compare per cycle
`timescale 1ns / 1ps
`default_nettype none
module kmc_search (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire kmc_pkg::srch_req_t req_i,
  output kmc_pkg::srch_rsp_t      rsp_o
);
  import kmc_pkg::*;

  logic          active_q, active_d;
  kw_cnt_t       lo_q, lo_d;
  kw_cnt_t       hi_q, hi_d;
  word_t         word_q, word_d;
  logic [KW_CNT_W:0] sum;
  kw_cnt_t       mid;
  word_t         key;
  logic          eq, lt, empty_nxt;

  always_comb begin
    sum       = {1'b0, lo_q} + {1'b0, hi_q};
    mid       = sum[KW_CNT_W:1];
    key       = keyword_rom(ROM_IDX_W'(mid));
    eq        = (word_q == key);
    lt        = (word_q < key);
    empty_nxt = lt ? (lo_q >= mid) : (({1'b0, mid} + 1'b1) >= {1'b0, hi_q});

    rsp_o.done  = active_q && (eq || empty_nxt);
    rsp_o.hit   = active_q && eq;
    rsp_o.probe = KW_IDX_W'(mid);
  end

  always_comb begin
    active_d = active_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    word_d   = word_q;
    if (req_i.start) begin
      active_d = 1'b1;
      lo_d     = '0;
      hi_d     = KW_CNT_W'(KW_USED);
      word_d   = req_i.word;
    end else if (active_q) begin
      if (rsp_o.done) begin
        active_d = 1'b0;
      end else if (lt) begin
        hi_d = mid;
      end else begin
        lo_d = mid + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    word_q <= word_d;
  end

endmodule
`default_nettype wire

>>> src/keyword_match_counter.sv
// Top level: keyword histogram with binary-search lookup and report sequencer
//
//   channel | dir | payload                                       | handshake
//   in_i    | in  | cmd, word_text, word_too_long                 | valid/ready
//   out_o   | out | found, keyword_index, keyword_count, last     | valid/ready
//
// Count hit: accept, 1 to 6 search probes, counter update, hand-off.
// Count miss: no update; a word that cannot match skips the search too.
// Report item: accept, then read, data and hand-off per nonzero keyword; hand-off alone if all zero.
// The search unit's single table compare paces the count path; the counter RAM's registered
// read paces the report path. Counters reset via per-keyword nonzero flags, no sweep.
// Results leave through an output register; a stalled sink holds the sequencer at hand-off.
`timescale 1ns / 1ps
`default_nettype none
module keyword_match_counter (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kmc_in_if.sink    in_i,
  kmc_out_if.source out_o
);
  import kmc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SEARCH  = 6'b000010,
    ST_UPDATE  = 6'b000100,
    ST_REP_RD  = 6'b001000,
    ST_REP_DAT = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_e;

  function automatic kw_idx_t lowest_set(input kw_mask_t m);
    kw_idx_t r;
    r = '0;
    for (int i = KW_USED - 1; i >= 0; i--) begin
      if (m[i]) r = KW_IDX_W'(i);
    end
    return r;
  endfunction

  function automatic kw_mask_t above(input kw_idx_t k);
    kw_mask_t r;
    for (int i = 0; i < KW_USED; i++) begin
      r[i] = (i > int'(k));
    end
    return r;
  endfunction

  state_e   state_q, state_d;
  kw_idx_t  idx_q, idx_d;
  kw_mask_t nz_q, nz_d;
  logic     more_q, more_d;
  logic     res_found_q, res_found_d;
  kw_idx_t  res_idx_q, res_idx_d;
  count_t   res_cnt_q, res_cnt_d;
  logic     res_last_q, res_last_d;
  logic     out_valid_q, out_valid_d;
  logic     out_found_q, out_found_d;
  kw_idx_t  out_idx_q, out_idx_d;
  count_t   out_cnt_q, out_cnt_d;
  logic     out_last_q, out_last_d;

  srch_req_t srch_req;
  srch_rsp_t srch_rsp;
  logic      ram_we;
  kw_idx_t   ram_raddr;
  count_t    ram_wdata, ram_rdata, cur_cnt;
  logic      in_acc, slot_free, rep_last;

  kmc_search u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (srch_req),
    .rsp_o  (srch_rsp)
  );

  kmc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (KW_USED)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready          = (state_q == ST_IDLE);
  assign in_acc              = in_i.valid && in_i.ready;
  assign slot_free           = !out_valid_q || out_o.ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.found         = out_found_q;
  assign out_o.keyword_index = OUT_IDX_W'(out_idx_q);
  assign out_o.keyword_count = count_out(out_cnt_q);
  assign out_o.last          = out_last_q;

  assign cur_cnt   = nz_q[idx_q] ? ram_rdata : '0;
  assign ram_wdata = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
  assign ram_we    = (state_q == ST_UPDATE);
  assign ram_raddr = (state_q == ST_SEARCH) ? srch_rsp.probe : idx_q;
  assign rep_last  = ~|(nz_q & above(idx_q));

  always_comb begin
    srch_req.start = in_acc && (in_i.cmd == CMD_COUNT) &&
                     word_eligible(in_i.word_text, in_i.word_too_long);
    srch_req.word  = in_i.word_text;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    nz_d        = nz_q;
    more_d      = more_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    res_cnt_d   = res_cnt_q;
    res_last_d  = res_last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_found_d = 1'b0;
          res_idx_d   = '0;
          res_cnt_d   = '0;
          res_last_d  = 1'b1;
          more_d      = 1'b0;
          if (in_i.cmd == CMD_REPORT) begin
            if (nz_q == '0) begin
              state_d = ST_EMIT;
            end else begin
              idx_d   = lowest_set(nz_q);
              state_d = ST_REP_RD;
            end
          end else if (srch_req.start) begin
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SEARCH: begin
        if (srch_rsp.done) begin
          if (srch_rsp.hit) begin
            idx_d   = srch_rsp.probe;
            state_d = ST_UPDATE;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_UPDATE: begin
        nz_d[idx_q] = 1'b1;
        res_found_d = 1'b1;
        res_idx_d   = idx_q;
        res_cnt_d   = ram_wdata;
        res_last_d  = 1'b1;
        more_d      = 1'b0;
        state_d     = ST_EMIT;
      end
      ST_REP_RD: begin
        state_d = ST_REP_DAT;
      end
      ST_REP_DAT: begin
        res_found_d = 1'b1;
        res_idx_d   = idx_q;
        res_cnt_d   = ram_rdata;
        res_last_d  = rep_last;
        more_d      = !rep_last;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_idx_d   = res_idx_q;
          out_cnt_d   = res_cnt_q;
          out_last_d  = res_last_q;
          if (more_q) begin
            idx_d   = lowest_set(nz_q & above(idx_q));
            state_d = ST_REP_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nz_q        <= '0;
      more_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nz_q        <= nz_d;
      more_q      <= more_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    res_cnt_q   <= res_cnt_d;
    res_last_q  <= res_last_d;
    out_found_q <= out_found_d;
    out_idx_q   <= out_idx_d;
    out_cnt_q   <= out_cnt_d;
    out_last_q  <= out_last_d;
  end

`ifndef NO_ASSERTIONS
  // a keyword, once counted, never reads as zero again
  a_nz_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ($past(nz_q) & ~nz_q) == '0)
    else $error("nonzero flag cleared");

  // update either increments or holds at saturation
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (ram_we && nz_q[idx_q]) |-> (ram_wdata == ram_rdata || ram_wdata == ram_rdata + 1'b1))
    else $error("counter update not a single step");

  // a miss carries a zero index and count
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && !out_found_q) |-> (out_idx_q == '0 && out_cnt_q == '0 && out_last_q))
    else $error("miss result with nonzero payload");
`endif

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Testbench for keyword_match_counter: directed and random word/report items, scoreboard check
`timescale 1ns / 1ps
module testbench;

  import kmc_pkg::*;

  localparam int   IDX_W       = OUT_IDX_W;
  localparam int   CNT_W       = OUT_CNT_W;
  localparam int   CYCLE_LIMIT = 500_000;
  localparam int   RANDOM_ITEMS = 136;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
    logic             last;
  } kw_result_t;

  class keyword_scoreboard;
    word_t      kw_words[ROM_SIZE];
    count_t     kw_counts[ROM_SIZE];
    kw_result_t expected_q[$];
    int         errors;

    function new();
      string names[ROM_SIZE] = '{
        "auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "else", "enum", "extern", "float", "for", "goto", "if",
        "int", "long", "register", "return", "short", "signed", "sizeof",
        "static", "struct", "switch", "typedef", "union", "unsigned", "void",
        "volatile", "while"};
      word_t w;
      errors = 0;
      for (int k = 0; k < ROM_SIZE; k++) begin
        w = '0;
        for (int c = 0; c < names[k].len() && c < 8; c++)
          w[63-8*c -: 8] = names[k][c];
        kw_words[k]  = w;
        kw_counts[k] = '0;
      end
    endfunction

    function void push_result(logic found, int index, count_t count, logic last);
      kw_result_t r;
      r.found = found;
      r.index = IDX_W'(index);
      r.count = CNT_W'(count);
      r.last  = last;
      expected_q.push_back(r);
    endfunction

    function void note_input(logic cmd, word_t text, logic too_long);
      logic [7:0] first;
      logic       eligible;
      int         hit;
      int         last_nz;
      hit = -1;
      last_nz = -1;
      if (cmd == CMD_REPORT) begin
        for (int k = 0; k < KW_USED; k++)
          if (kw_counts[k] != '0) last_nz = k;
        if (last_nz < 0) begin
          push_result(1'b0, 0, '0, 1'b1);
        end else begin
          for (int k = 0; k <= last_nz; k++)
            if (kw_counts[k] != '0) push_result(1'b1, k, kw_counts[k], k == last_nz);
        end
      end else begin
        first = text[63:56];
        eligible = ((first >= "A" && first <= "Z") || (first >= "a" && first <= "z"))
                   && !too_long;
        if (MAX_KEY_CHARS < 8 && (text << (8 * MAX_KEY_CHARS)) != '0) eligible = 1'b0;
        if (eligible)
          for (int k = 0; k < KW_USED; k++)
            if (kw_words[k] == text) hit = k;
        if (hit >= 0) begin
          if (kw_counts[hit] != '1) kw_counts[hit] = kw_counts[hit] + 1'b1;
          push_result(1'b1, hit, kw_counts[hit], 1'b1);
        end else begin
          push_result(1'b0, 0, '0, 1'b1);
        end
      end
    endfunction

    function void check_result(logic found, logic [IDX_W-1:0] index,
                               logic [CNT_W-1:0] count, logic last);
      kw_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: found=%0d index=%0d count=%0d last=%0d",
                   found, index, count, last);
        return;
      end
      want = expected_q.pop_front();
      if (want.found !== found || want.index !== index ||
          want.count !== count || want.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %0d %0d %0d %0d act %0d %0d %0d %0d (found idx count last)",
                   want.found, want.index, want.count, want.last,
                   found, index, count, last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_cycles;
  int   cycle_count;

  keyword_scoreboard sb;

  kmc_in_if  in_if ();
  kmc_out_if out_if ();

  keyword_match_counter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input word_t text, input logic too_long);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.cmd           <= cmd;
    in_if.word_text     <= text;
    in_if.word_too_long <= too_long;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(cmd, text, too_long);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.found, out_if.keyword_index, out_if.keyword_count,
                        out_if.last);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    word_t w;
    logic  cmd;
    logic  too_long;
    int    pick;
    int    len;
    int    b;

    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.cmd           = CMD_COUNT;
    in_if.word_text     = '0;
    in_if.word_too_long = 1'b0;
    send_idle_pct       = 11;
    recv_idle_pct       = 88;
    hold_cycles         = 0;
    cycle_count         = 0;
    sb = new();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_item(CMD_REPORT, '0, 1'b0);                       // empty report
    send_item(CMD_COUNT, {"auto", 32'h0}, 1'b0);           // first entry
    send_item(CMD_COUNT, {"auto", 32'h0}, 1'b0);
    send_item(CMD_COUNT, {"while", 24'h0}, 1'b0);          // last entry
    send_item(CMD_COUNT, {"do", 48'h0}, 1'b0);
    send_item(CMD_COUNT, "continue", 1'b0);                // full-width keywords
    send_item(CMD_COUNT, "register", 1'b0);
    send_item(CMD_COUNT, "unsigned", 1'b0);
    send_item(CMD_COUNT, "volatile", 1'b0);
    send_item(CMD_COUNT, {"auto", 32'h0}, 1'b1);           // over-long flag
    send_item(CMD_COUNT, {"au", 8'h0, "to", 24'h0}, 1'b0); // gap in padding
    send_item(CMD_COUNT, {"Auto", 32'h0}, 1'b0);
    send_item(CMD_COUNT, {"zebra", 24'h0}, 1'b0);
    send_item(CMD_COUNT, {"Zebra", 24'h0}, 1'b0);
    send_item(CMD_COUNT, {"@uto", 32'h0}, 1'b0);           // just outside letter ranges
    send_item(CMD_COUNT, {"[uto", 32'h0}, 1'b0);
    send_item(CMD_COUNT, {8'h60, "uto", 32'h0}, 1'b0);
    send_item(CMD_COUNT, {"{uto", 32'h0}, 1'b0);
    send_item(CMD_COUNT, {"1f", 48'h0}, 1'b0);
    send_item(CMD_COUNT, '0, 1'b0);
    send_item(CMD_COUNT, '1, 1'b1);
    send_item(CMD_REPORT, '1, 1'b1);                       // payload ignored
    send_item(CMD_REPORT, '0, 1'b0);

    // random
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 88;
        recv_idle_pct = 11;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 400;
      end
      pick = $urandom_range(99);
      w = sb.kw_words[$urandom_range(KW_USED - 1)];
      if (pick < 55) begin
        // exact keyword
      end else if (pick < 65) begin
        b = $urandom_range(63);
        w[b] = ~w[b];
      end else if (pick < 75) begin
        w[63:56] = w[63:56] ^ 8'h20;
      end else if (pick < 85) begin
        w = '0;
        len = $urandom_range(1, 8);
        for (int c = 0; c < len; c++) w[63-8*c -: 8] = 8'($urandom_range("a", "z"));
      end else begin
        w = {$urandom, $urandom};
      end
      cmd      = ($urandom_range(99) < 10) ? CMD_REPORT : CMD_COUNT;
      too_long = ($urandom_range(99) < 8);
      send_item(cmd, w, too_long);
    end
    send_item(CMD_REPORT, '0, 1'b0);
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/kmc_pkg.sv
src/kmc_if.sv
src/kmc_ram.sv
src/kmc_search.sv
src/keyword_match_counter.sv
tb/testbench.sv
